FILE: rtl/w3bsf_pkg.sv
package w3bsf_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int INDEX_W = 2;
    localparam int SUM_W   = 12;
    localparam int GRAD_W  = 11;

    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [INDEX_W-1:0] REG_FILTER_MODE  = 2'd2;

    localparam logic MODE_BOX   = 1'b0;
    localparam logic MODE_SOBEL = 1'b1;
    localparam logic DEF_MODE   = MODE_SOBEL;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int PIX_MAX = 255;

    // floor(x / 9) == (x * 3641) >> 15 for x < 32768
    localparam int RECIP_W    = 12;
    localparam int RECIP_9    = 3641;
    localparam int RECIP_SH   = 15;
    localparam int ROUND_BIAS = 4;

    localparam int MIDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic       command;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] filtered_value;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic mask_top;
        logic mask_bottom;
        logic mask_left;
        logic mask_right;
    } work_flags_t;

    function automatic logic [GRAD_W-1:0] weigh3(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        return GRAD_W'(a) + (GRAD_W'(b) << 1) + GRAD_W'(c);
    endfunction

    function automatic logic [PIX_W-1:0] clip_abs(input logic signed [GRAD_W-1:0] g);
        logic [GRAD_W-1:0] mag;
        mag = g[GRAD_W-1] ? GRAD_W'(-g) : GRAD_W'(g);
        return (mag > GRAD_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : mag[PIX_W-1:0];
    endfunction

endpackage

FILE: rtl/w3bsf_fifo.sv
module w3bsf_fifo
    import w3bsf_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LW   = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wdata,
    output logic          full,
    input  logic          pop,
    output logic [DW-1:0] rdata,
    output logic          empty,
    output logic [LW-1:0] level
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == LW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + LW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/w3bsf_front.sv
module w3bsf_front
    import w3bsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW        = $clog2(MAX_WIDTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               accept,
    input  in_item_t           item,
    output work_flags_t        desc_flags,
    output logic [PIX_W-1:0]   desc_pixel,
    output logic [CW-1:0]      desc_col,
    output logic               mode
);

    localparam int HW   = $clog2(MAX_HEIGHT);
    localparam int IRW  = $clog2(MAX_HEIGHT + 2);
    localparam int WEW  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HEW  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int W_RST = (DEF_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_FRAME_WIDTH;
    localparam int H_RST = (DEF_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEF_FRAME_HEIGHT;

    logic [CW-1:0]  w_last_reg, w_last_next;
    logic [HW-1:0]  h_last_reg, h_last_next;
    logic           mode_reg, mode_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [IRW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]  cen_col_reg, cen_col_next;
    logic [HW-1:0]  cen_row_reg, cen_row_next;

    logic [WEW-1:0] w_ext;
    logic [HEW-1:0] h_ext;
    logic [CW-1:0]  w_pick;
    logic [HW-1:0]  h_pick;
    logic           cfg_hit;
    logic           past_frame;

    assign w_ext = WEW'(cfg_data);
    assign h_ext = HEW'(cfg_data);

    always_comb
    begin
        if (w_ext == '0)
        begin
            w_pick = '0;
        end
        else if (w_ext > WEW'(MAX_WIDTH))
        begin
            w_pick = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_pick = CW'(w_ext - WEW'(1));
        end
        if (h_ext == '0)
        begin
            h_pick = '0;
        end
        else if (h_ext > HEW'(MAX_HEIGHT))
        begin
            h_pick = HW'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_pick = HW'(h_ext - HEW'(1));
        end
    end

    // classification of the incoming beat at the input port
    assign past_frame = (in_row_reg > IRW'(h_last_reg));
    assign desc_pixel = (item.command == CMD_FLUSH || past_frame) ? '0 : item.pixel;
    assign desc_col   = in_col_reg;

    assign desc_flags.emit        = (in_row_reg >= IRW'(2))
                                 || (in_row_reg == IRW'(1) && in_col_reg != '0);
    assign desc_flags.mask_top    = (cen_row_reg == '0);
    assign desc_flags.mask_bottom = (cen_row_reg == h_last_reg);
    assign desc_flags.mask_left   = (cen_col_reg == '0);
    assign desc_flags.mask_right  = (cen_col_reg == w_last_reg);
    assign desc_flags.last        = desc_flags.emit && desc_flags.mask_bottom
                                 && desc_flags.mask_right;

    assign mode = mode_reg;

    always_comb
    begin
        w_last_next  = w_last_reg;
        h_last_next  = h_last_reg;
        mode_next    = mode_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        cen_col_next = cen_col_reg;
        cen_row_next = cen_row_reg;
        cfg_hit      = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    w_last_next = w_pick;
                    cfg_hit     = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    h_last_next = h_pick;
                    cfg_hit     = 1'b1;
                end
                REG_FILTER_MODE:
                begin
                    mode_next = cfg_data[0];
                    cfg_hit   = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        if (cfg_hit || (accept && desc_flags.last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            cen_col_next = '0;
            cen_row_next = '0;
        end
        else if (accept)
        begin
            if (in_col_reg == w_last_reg)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IRW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (desc_flags.emit)
            begin
                if (cen_col_reg == w_last_reg)
                begin
                    cen_col_next = '0;
                    cen_row_next = cen_row_reg + HW'(1);
                end
                else
                begin
                    cen_col_next = cen_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg  <= CW'(W_RST - 1);
            h_last_reg  <= HW'(H_RST - 1);
            mode_reg    <= DEF_MODE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            cen_col_reg <= '0;
            cen_row_reg <= '0;
        end
        else
        begin
            w_last_reg  <= w_last_next;
            h_last_reg  <= h_last_next;
            mode_reg    <= mode_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            cen_col_reg <= cen_col_next;
            cen_row_reg <= cen_row_next;
        end
    end

endmodule

FILE: rtl/w3bsf_back.sv
module w3bsf_back
    import w3bsf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW       = $clog2(MAX_WIDTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  avail,
    input  work_flags_t           desc_flags,
    input  logic [PIX_W-1:0]      desc_pixel,
    input  logic [CW-1:0]         desc_col,
    output logic                  take,
    input  logic [OUTQ_LVL_W-1:0] outq_level,
    input  logic                  mode,
    output logic                  res_push,
    output result_t               res_data
);

    localparam int OCW  = OUTQ_LVL_W + 1;
    localparam int PRDW = SUM_W + RECIP_W;

    logic [PIX_W-1:0] line_a_mem [MAX_WIDTH];
    logic [PIX_W-1:0] line_b_mem [MAX_WIDTH];

    logic [PIX_W-1:0] rd_a_reg;
    logic [PIX_W-1:0] rd_b_reg;
    logic [PIX_W-1:0] fwd_reg;

    logic             s1_valid_reg;
    work_flags_t      s1_flags_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_hit_reg;

    logic [PIX_W-1:0] win_reg [3][3];
    logic             s2_valid_reg;
    work_flags_t      s2_flags_reg;

    logic                     s3_valid_reg;
    logic                     s3_emit_reg;
    logic                     s3_last_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;

    logic [OCW-1:0]   occupancy;
    logic [PIX_W-1:0] col_top;
    logic [PIX_W-1:0] p [3][3];
    logic [SUM_W-1:0] row_sum [3];
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] biased;
    logic [PRDW-1:0]  prod;
    logic [PIX_W:0]   grad_sum;
    logic [PIX_W-1:0] half;
    logic [PIX_W-1:0] box_val;
    logic [PIX_W-1:0] sobel_val;

    // issue only with room reserved in the result queue
    assign occupancy = OCW'(outq_level) + OCW'(s1_valid_reg) + OCW'(s2_valid_reg)
                     + OCW'(s3_valid_reg);
    assign take      = avail && (occupancy < OCW'(OUTQ_DEPTH));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_a_reg             <= line_a_mem[desc_col];
            line_a_mem[desc_col] <= desc_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_b_reg <= line_b_mem[desc_col];
        end
        if (s1_valid_reg)
        begin
            line_b_mem[s1_col_reg] <= rd_a_reg;
        end
    end

    // stage 1 payload; hit covers a read of line B in the cycle it is written
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_flags_reg <= desc_flags;
            s1_pixel_reg <= desc_pixel;
            s1_col_reg   <= desc_col;
            s1_hit_reg   <= s1_valid_reg && (s1_col_reg == desc_col);
        end
        if (s1_valid_reg)
        begin
            fwd_reg      <= rd_a_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    assign col_top = s1_hit_reg ? fwd_reg : rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= col_top;
                win_reg[1][2] <= rd_a_reg;
                win_reg[2][2] <= s1_pixel_reg;
            end
        end
    end

    // stage 2: zero padding, box sum and gradients
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && s2_flags_reg.mask_top) || (r == 2 && s2_flags_reg.mask_bottom)
                    || (c == 0 && s2_flags_reg.mask_left)
                    || (c == 2 && s2_flags_reg.mask_right))
                begin
                    p[r][c] = '0;
                end
                else
                begin
                    p[r][c] = win_reg[r][c];
                end
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = SUM_W'(p[r][0]) + SUM_W'(p[r][1]) + SUM_W'(p[r][2]);
        end
        sum = row_sum[0] + row_sum[1] + row_sum[2];
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_emit_reg <= s2_flags_reg.emit;
            s3_last_reg <= s2_flags_reg.last;
            sum_reg     <= sum;
            gx_reg      <= $signed(weigh3(p[0][2], p[1][2], p[2][2])
                                 - weigh3(p[0][0], p[1][0], p[2][0]));
            gy_reg      <= $signed(weigh3(p[2][0], p[2][1], p[2][2])
                                 - weigh3(p[0][0], p[0][1], p[0][2]));
        end
    end

    // stage 3: rounded mean or magnitude average
    always_comb
    begin
        biased    = sum_reg + SUM_W'(ROUND_BIAS);
        prod      = PRDW'(biased) * PRDW'(RECIP_9);
        box_val   = prod[RECIP_SH +: PIX_W];
        grad_sum  = (PIX_W + 1)'(clip_abs(gx_reg)) + (PIX_W + 1)'(clip_abs(gy_reg));
        half      = grad_sum[PIX_W:1];
        sobel_val = (grad_sum[0] && half[0]) ? half + PIX_W'(1) : half;
    end

    assign res_push                = s3_valid_reg && s3_emit_reg;
    assign res_data.filtered_value = (mode == MODE_BOX) ? box_val : sobel_val;
    assign res_data.frame_end      = s3_last_reg;

endmodule

FILE: rtl/window_3x3_box_or_sobel_filter_top.sv
// Path: a result passes the work queue, the back-end stages and the result queue
// after the beat that ends its window (pixel k+W+1 of the frame, or a flush beat)
// is accepted. Throughput: one beat per cycle in and out while results are popped,
// set by the single write per cycle of each line store.
// Reset: queues, pipeline, window and position counters clear; registers load
// width 640, height 480, Sobel mode; line store contents are left as they are.
module window_3x3_box_or_sobel_filter_top
    import w3bsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               push,
    input  in_item_t           item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output result_t            result
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int MIDQ_W = $bits(work_flags_t) + PIX_W + CW;
    localparam int MIDQ_L = $clog2(MIDQ_DEPTH + 1);
    localparam int RES_W  = $bits(result_t);

    logic                  accept;
    work_flags_t           desc_flags;
    logic [PIX_W-1:0]      desc_pixel;
    logic [CW-1:0]         desc_col;
    logic                  mode;

    logic [MIDQ_W-1:0]     midq_rdata;
    logic                  midq_empty;
    logic [MIDQ_L-1:0]     midq_level;
    work_flags_t           head_flags;
    logic [PIX_W-1:0]      head_pixel;
    logic [CW-1:0]         head_col;

    logic                  take;
    logic                  res_push;
    result_t               res_data;
    logic                  outq_full;
    logic [OUTQ_LVL_W-1:0] outq_level;
    logic [RES_W-1:0]      outq_rdata;

    assign accept = push && !full;

    w3bsf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .item       (item),
        .desc_flags (desc_flags),
        .desc_pixel (desc_pixel),
        .desc_col   (desc_col),
        .mode       (mode)
    );

    w3bsf_fifo #(
        .DW    (MIDQ_W),
        .DEPTH (MIDQ_DEPTH)
    ) u_midq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({desc_flags, desc_pixel, desc_col}),
        .full  (full),
        .pop   (take),
        .rdata (midq_rdata),
        .empty (midq_empty),
        .level (midq_level)
    );

    assign {head_flags, head_pixel, head_col} = midq_rdata;

    w3bsf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .avail      (!midq_empty && (midq_level != '0)),
        .desc_flags (head_flags),
        .desc_pixel (head_pixel),
        .desc_col   (head_col),
        .take       (take),
        .outq_level (outq_level),
        .mode       (mode),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    w3bsf_fifo #(
        .DW    (RES_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (outq_full),
        .pop   (pop),
        .rdata (outq_rdata),
        .empty (empty),
        .level (outq_level)
    );

    assign result = outq_rdata;

`ifndef SYNTHESIS
    a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !outq_full)
        else $error("result pushed into a full queue");

    a_midq_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !midq_empty)
        else $error("work taken from an empty queue");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && desc_flags.last) |=> !desc_flags.emit)
        else $error("position counters not restarted after frame end");
`endif

endmodule

FILE: bench/tb_window_3x3_box_or_sobel_filter_top.sv
`timescale 1ns / 1ps

module tb_window_3x3_box_or_sobel_filter_top;
    import w3bsf_pkg::*;

    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int MAX_H       = DEF_MAX_HEIGHT;
    localparam int LINE_LEN    = 2 * MAX_W + 3;
    localparam int STALL_LIMIT = 2000;
    localparam int SMALL_ITEMS = 750;
    localparam int SETTLE      = 8;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_write = 1'b0;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               push      = 1'b0;
    in_item_t           item      = '0;
    logic               full;
    logic               empty;
    logic               pop       = 1'b0;
    result_t            result;

    window_3x3_box_or_sobel_filter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    in_item_t         pending_beats[$];
    result_t          expected_pixels[$];
    result_t          oldest_pixel;
    logic [7:0]       delay_line [LINE_LEN] = '{default: '0};
    logic [CFG_W-1:0] width_reg  = CFG_W'(DEF_FRAME_WIDTH);
    logic [CFG_W-1:0] height_reg = CFG_W'(DEF_FRAME_HEIGHT);
    logic             mode_reg   = DEF_MODE;
    int               in_col     = 0;
    int               in_row     = 0;
    int               ctr_row    = 0;
    int               ctr_col    = 0;
    int               wr_pos     = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;
    int               queued     = 0;
    bit               calm       = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lim);
        if (v == '0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    function automatic int sat_mag(input int g);
        int a;
        a = (g < 0) ? -g : g;
        return (a > PIX_MAX) ? PIX_MAX : a;
    endfunction

    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'd0;
        if (r < 20)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    task automatic restart_position();
        in_col  = 0;
        in_row  = 0;
        ctr_row = 0;
        ctr_col = 0;
        wr_pos  = 0;
    endtask

    // one accepted beat through the line delay and the 3x3 window
    task automatic filter_beat(input in_item_t b);
        int      w, h, len, val, sum, gx, gy, rr, cc, px, back, s, res;
        bit      last;
        result_t r;
        w    = clamp_dim(width_reg, MAX_W);
        h    = clamp_dim(height_reg, MAX_H);
        len  = 2 * w + 3;
        val  = (b.command == CMD_FLUSH || in_row >= h) ? 0 : int'(b.pixel);
        last = 1'b0;
        delay_line[wr_pos] = 8'(val);
        if (in_row >= 2 || (in_row == 1 && in_col >= 1))
        begin
            sum = 0;
            gx  = 0;
            gy  = 0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    rr = ctr_row + dr;
                    cc = ctr_col + dc;
                    px = 0;
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w)
                    begin
                        back = w + 1 - dr * w - dc;
                        px   = int'(delay_line[(wr_pos + len - back) % len]);
                    end
                    sum += px;
                    gx  += dc * ((dr == 0) ? 2 : 1) * px;
                    gy  += dr * ((dc == 0) ? 2 : 1) * px;
                end
            end
            if (mode_reg == MODE_BOX)
                res = (sum + ROUND_BIAS) / 9;
            else
            begin
                s   = sat_mag(gx) + sat_mag(gy);
                res = s >> 1;
                if ((s & 1) && (res & 1))
                    res += 1;
            end
            if (res > PIX_MAX)
                res = PIX_MAX;
            last             = (ctr_row == h - 1 && ctr_col == w - 1);
            r.filtered_value = 8'(res);
            r.frame_end      = last;
            expected_pixels.push_back(r);
            ctr_col++;
            if (ctr_col >= w)
            begin
                ctr_col = 0;
                ctr_row++;
            end
        end
        wr_pos = (wr_pos + 1) % len;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row = (in_row + 1) & 'h7FF;
        end
        if (last)
            restart_position();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
                filter_beat(item);
            if (!push || !full)
            begin
                if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 9))
                begin
                    item <= pending_beats.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected beat: value %0d frame_end %0b",
                                 result.filtered_value, result.frame_end);
                    mismatches++;
                end
                else
                begin
                    oldest_pixel = expected_pixels.pop_front();
                    if (result.filtered_value !== oldest_pixel.filtered_value ||
                        result.frame_end !== oldest_pixel.frame_end)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected value %0d frame_end %0b, got %0d %0b",
                                     oldest_pixel.filtered_value, oldest_pixel.frame_end,
                                     result.filtered_value, result.frame_end);
                        mismatches++;
                    end
                end
            end
            pop <= calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() != 0 || push || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(input int w, input int h, input logic m);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        cfg_index <= REG_FILTER_MODE;
        cfg_data  <= CFG_W'(m);
        @(posedge clk);
        cfg_write <= 1'b0;
        width_reg  = CFG_W'(w);
        height_reg = CFG_W'(h);
        mode_reg   = m;
        restart_position();
    endtask

    task automatic push_beat(input logic cmd, input logic [7:0] pix);
        in_item_t b;
        b.command = cmd;
        b.pixel   = pix;
        pending_beats.push_back(b);
        queued++;
    endtask

    // full frame plus trailing pixel or flush beats; rough frames may be cut short or paused
    task automatic add_frame(input int w, input int h, input bit rough);
        int cut, pause_at, total;
        total    = w * h + w + 1;
        cut      = total;
        pause_at = -1;
        if (rough && $urandom_range(99) < 10)
            cut = $urandom_range(total - 1);
        if (rough && $urandom_range(99) < 10)
            pause_at = $urandom_range(1, total - 1);
        for (int i = 0; i < cut; i++)
        begin
            if (i == pause_at)
                wait_drained();
            if (i < w * h)
                push_beat(($urandom_range(99) < 4) ? CMD_FLUSH : CMD_PIXEL, pick_pixel());
            else
                push_beat($urandom_range(1) ? CMD_FLUSH : CMD_PIXEL, pick_pixel());
        end
    endtask

    task automatic run_phase(input int w, input int h, input logic m, input int frames,
                             input bit rough, input bit quiet);
        int ew, eh;
        write_regs(w, h, m);
        calm = quiet;
        ew   = clamp_dim(CFG_W'(w), MAX_W);
        eh   = clamp_dim(CFG_W'(h), MAX_H);
        for (int f = 0; f < frames; f++)
            add_frame(ew, eh, rough);
        if (rough && $urandom_range(99) < 10)
        begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
                push_beat(1'($urandom_range(1)), pick_pixel());
        end
    endtask

    initial
    begin
        int w, h, r, p;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_regs(3, 2, MODE_BOX);
        push_beat(CMD_PIXEL, 8'd0);
        push_beat(CMD_PIXEL, 8'd255);
        push_beat(CMD_PIXEL, 8'd255);
        push_beat(CMD_FLUSH, 8'hA5);
        push_beat(CMD_PIXEL, 8'd255);
        push_beat(CMD_PIXEL, 8'd0);
        push_beat(CMD_FLUSH, 8'd0);
        push_beat(CMD_PIXEL, 8'd77);
        push_beat(CMD_FLUSH, 8'd255);
        push_beat(CMD_PIXEL, 8'd255);

        write_regs(3, 3, MODE_SOBEL);
        for (int i = 0; i < 13; i++)
        begin
            if (i == 5)
                wait_drained();
            push_beat((i < 9) ? CMD_PIXEL : CMD_FLUSH, (i % 3 == 0) ? 8'd255 : 8'd0);
        end

        p = 0;
        while (queued < SMALL_ITEMS)
        begin
            r = $urandom_range(99);
            w = (r < 5) ? 0 : (r < 10) ? 1 : $urandom_range(2, 9);
            r = $urandom_range(99);
            h = (r < 5) ? 0 : (r < 10) ? 1 : $urandom_range(2, 6);
            run_phase(w, h, 1'($urandom_range(1)), $urandom_range(1, 3), 1'b1, p == 12);
            p++;
        end

        run_phase(1, 2047, MODE_SOBEL, 1, 1'b0, 1'b1);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: window_3x3_box_or_sobel_filter_top.f
rtl/w3bsf_pkg.sv
rtl/w3bsf_fifo.sv
rtl/w3bsf_front.sv
rtl/w3bsf_back.sv
rtl/window_3x3_box_or_sobel_filter_top.sv
bench/tb_window_3x3_box_or_sobel_filter_top.sv
